>>> rtl/core/wpm_pkg.sv
// Package for the wildcard pattern matcher: constants, action codes and payload types.
package wpm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int COUNT_W         = 6;

  localparam logic [7:0] SYM_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] SYM_ANY_RUN = 8'h2A;  // '*'

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
    logic       text_end;
  } wpm_in_t;

  typedef struct packed {
    logic               matched;
    logic               pattern_full;
    logic [COUNT_W-1:0] pattern_count;
  } wpm_out_t;

endpackage

>>> rtl/core/wildcard_pattern_matcher.sv
// Wildcard pattern matcher: pattern store, parallel match row and result skid buffer.
// A result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one item per cycle while in_ready is high; the whole match row updates in one pass
// through a log-depth prefix network that resolves runs of '*'.
// in_ready drops only while the skid register holds a result that is stalled.
// Reset (rst_n, synchronous, active low): empty pattern, row holds bit zero, no results.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wpm_pkg::wpm_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wpm_pkg::wpm_out_t out_data
);

  localparam int N  = PATTERN_MAX + 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LV = $clog2(N);
  localparam logic [N-1:0] ROW_INIT = N'(1);

  // pattern store, undefined until written; flags decoded at write time
  logic [7:0] pat_sym_r  [PATTERN_MAX];
  logic       pat_star_r [PATTERN_MAX];
  logic       pat_any_r  [PATTERN_MAX];

  logic [LW-1:0] len_r, len_nxt;
  logic [N-1:0]  row_r, row_nxt;
  logic [N-1:0]  start_r, start_nxt;

  logic              out_valid_r, skid_valid_r;
  wpm_pkg::wpm_out_t out_data_r, skid_data_r;

  logic              in_fire, out_fire, wr_en, full, hit, sym_star;
  logic [N-1:0]      text_row;
  logic [N-1:0]      gen   [LV+1];
  logic [N-1:0]      prop  [LV+1];
  wpm_pkg::wpm_out_t res;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign sym_star  = (in_data.symbol == wpm_pkg::SYM_ANY_RUN);

  // next row for a text byte: '*' positions propagate from the left,
  // others generate from the diagonal; prefix network resolves star runs
  always_comb begin
    gen[0]  = '0;
    prop[0] = '0;
    for (int j = 1; j < N; j++) begin
      if (LW'(j) <= len_r) begin
        if (pat_star_r[j-1]) begin
          gen[0][j]  = row_r[j];
          prop[0][j] = 1'b1;
        end else begin
          gen[0][j] = (pat_any_r[j-1] || (pat_sym_r[j-1] == in_data.symbol)) && row_r[j-1];
        end
      end
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < N; j++) begin
        if (j >= (1 << l)) begin
          gen[l+1][j]  = gen[l][j] | (prop[l][j] & gen[l][j-(1<<l)]);
          prop[l+1][j] = prop[l][j] & prop[l][j-(1<<l)];
        end else begin
          gen[l+1][j]  = gen[l][j];
          prop[l+1][j] = prop[l][j];
        end
      end
    end
    text_row = gen[LV];
  end

  always_comb begin
    len_nxt   = len_r;
    row_nxt   = row_r;
    start_nxt = start_r;
    full      = 1'b0;
    wr_en     = 1'b0;
    unique case (in_data.action)
      wpm_pkg::ACT_CLEAR: begin
        len_nxt   = '0;
        start_nxt = ROW_INIT;
        row_nxt   = ROW_INIT;
      end
      wpm_pkg::ACT_APPEND: begin
        if (len_r >= LW'(PATTERN_MAX)) begin
          full = 1'b1;
        end else begin
          wr_en = 1'b1;
          len_nxt = LW'(len_r + 1'b1);
          start_nxt[LW'(len_r + 1'b1)] = start_r[len_r] && sym_star;
          row_nxt = start_nxt;
        end
      end
      wpm_pkg::ACT_TEXT: begin
        row_nxt = text_row;
      end
      default: begin
      end
    endcase
    hit = row_nxt[len_nxt];
    if (in_data.action == wpm_pkg::ACT_TEXT && in_data.text_end) begin
      row_nxt = start_r;
    end
    res.matched       = hit;
    res.pattern_full  = full;
    res.pattern_count = wpm_pkg::COUNT_W'(len_nxt);
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      pat_sym_r[len_r[AW-1:0]]  <= in_data.symbol;
      pat_star_r[len_r[AW-1:0]] <= sym_star;
      pat_any_r[len_r[AW-1:0]]  <= (in_data.symbol == wpm_pkg::SYM_ANY_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      row_r   <= ROW_INIT;
      start_r <= ROW_INIT;
    end else if (in_fire) begin
      len_r   <= len_nxt;
      row_r   <= row_nxt;
      start_r <= start_nxt;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
